>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stable priority queue with boost.
package spq_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam int KIND_W   = 2;
   localparam int ID_W     = 16;
   localparam int LETTER_W = 8;
   localparam int PRIO_W   = 32;
   localparam int STAMP_W  = 32;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 2;

   localparam logic [KIND_W-1:0] KIND_ARRIVE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BOOST  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SERVE  = 2'd2;

   // Controller to datapath commands.
   typedef struct packed {
      logic start;   // transaction accepted, latch request, clear scan results
      logic rd_en;   // read slot memory at the scan index
      logic commit;  // apply result to state and load the output register
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic out_free;  // output register can take a new result this cycle
   } status_type;

   // One stored entry.
   typedef struct packed {
      logic [STAMP_W-1:0]  arrival;
      logic [PRIO_W-1:0]   prio;
      logic [LETTER_W-1:0] letter;
      logic [ID_W-1:0]     id;
   } slot_type;

endpackage

>>> rtl/spq_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: accept, slot sweep, drain and commit.
module spq_ctrl import spq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int IDX_W    = $clog2(CAPACITY_DEF)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  status_type       status,
   output cmd_type          cmd,
   output logic [IDX_W-1:0] rd_idx
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               idx_in    = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_idx = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

>>> rtl/spq_dp.sv
`timescale 1ns / 1ps
// Datapath: slot memory, valid bits, scan compare, boost update and result register.
module spq_dp import spq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int IDX_W    = $clog2(CAPACITY_DEF)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [IDX_W-1:0]      rd_idx,
   output status_type            status,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [REQ_DATA_W-1:0] req_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   // latched request
   logic [KIND_W-1:0]   kind_ff;
   logic [ID_W-1:0]     id_ff;
   logic [LETTER_W-1:0] letter_ff;
   logic [PRIO_W-1:0]   prio_ff;
   logic [PRIO_W-1:0]   inc_ff;

   slot_type         slot_mem_ff [CAPACITY];
   slot_type         rd_data_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             rd_vld_ff;

   logic [CAPACITY-1:0] valid_ff;
   logic [STAMP_W-1:0]  counter_ff;

   logic               best_found_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [PRIO_W-1:0]  best_prio_ff;
   logic [STAMP_W-1:0] best_arr_ff;
   logic [ID_W-1:0]    best_id_ff;

   logic             free_found_ff;
   logic [IDX_W-1:0] free_idx_ff;

   logic                  rsp_vld_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   logic              slot_ok;
   logic              goes_first;
   logic [PRIO_W:0]   sum;
   logic [PRIO_W-1:0] sat_prio;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa;
   slot_type          mem_wd;
   logic              do_arrive;
   logic              do_serve;

   assign status.out_free = !rsp_vld_ff || rsp_tready;
   assign slot_ok = valid_ff[rd_idx_ff];

   always_comb begin
      if (rd_data_ff.prio != best_prio_ff) begin
         goes_first = $signed(rd_data_ff.prio) > $signed(best_prio_ff);
      end else begin
         goes_first = rd_data_ff.arrival < best_arr_ff;
      end
   end

   // saturating boost sum
   always_comb begin
      sum = {rd_data_ff.prio[PRIO_W-1], rd_data_ff.prio} + {inc_ff[PRIO_W-1], inc_ff};
      if (sum[PRIO_W] != sum[PRIO_W-1]) begin
         sat_prio = sum[PRIO_W] ? {1'b1, {(PRIO_W-1){1'b0}}} : {1'b0, {(PRIO_W-1){1'b1}}};
      end else begin
         sat_prio = sum[PRIO_W-1:0];
      end
   end

   assign do_arrive = cmd.commit && (kind_ff == KIND_ARRIVE) && free_found_ff;
   assign do_serve  = cmd.commit && (kind_ff == KIND_SERVE) && best_found_ff;

   // one write port: boost updates during the sweep, arrival store at commit
   always_comb begin
      mem_we = 1'b0;
      mem_wa = rd_idx_ff;
      mem_wd = rd_data_ff;
      if (do_arrive) begin
         mem_we         = 1'b1;
         mem_wa         = free_idx_ff;
         mem_wd.id      = id_ff;
         mem_wd.letter  = letter_ff;
         mem_wd.prio    = prio_ff;
         mem_wd.arrival = counter_ff;
      end else if (rd_vld_ff && (kind_ff == KIND_BOOST) && slot_ok
                   && (rd_data_ff.letter == letter_ff)) begin
         mem_we      = 1'b1;
         mem_wd.prio = sat_prio;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_idx];
      end
      rd_idx_ff <= rd_idx;
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         kind_ff   <= req_kind;
         id_ff     <= req_data[15:0];
         letter_ff <= req_data[23:16];
         prio_ff   <= req_data[55:24];
         inc_ff    <= req_data[87:56];
      end
   end

   // scan results; payload parts need no reset
   always_ff @(posedge clock) begin
      if (rd_vld_ff && (kind_ff == KIND_SERVE) && slot_ok
          && (!best_found_ff || goes_first)) begin
         best_idx_ff  <= rd_idx_ff;
         best_prio_ff <= rd_data_ff.prio;
         best_arr_ff  <= rd_data_ff.arrival;
         best_id_ff   <= rd_data_ff.id;
      end
      if (rd_vld_ff && (kind_ff == KIND_ARRIVE) && !slot_ok && !free_found_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         valid_ff      <= '0;
         counter_ff    <= '0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_en;
         if (cmd.start) begin
            best_found_ff <= 1'b0;
            free_found_ff <= 1'b0;
         end else if (rd_vld_ff) begin
            if ((kind_ff == KIND_SERVE) && slot_ok) begin
               best_found_ff <= 1'b1;
            end
            if ((kind_ff == KIND_ARRIVE) && !slot_ok) begin
               free_found_ff <= 1'b1;
            end
         end
         if (do_arrive) begin
            valid_ff[free_idx_ff] <= 1'b1;
            counter_ff            <= counter_ff + 1'b1;
         end
         if (do_serve) begin
            valid_ff[best_idx_ff] <= 1'b0;
         end
         if (cmd.commit) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff    <= do_serve ? best_id_ff : '0;
         rsp_user_ff[0] <= do_serve;
         rsp_user_ff[1] <= (kind_ff == KIND_ARRIVE) && !free_found_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> rtl/stable_priority_queue_with_boost.sv
`timescale 1ns / 1ps
// Stable priority queue with boost by letter: CAPACITY entries, FIFO order on equal priority.
//
// Input channel req_*: one transaction per event, kind on req_tuser (arrival, boost, serve).
// Result channel rsp_*: exactly one transaction per accepted event, in order.
// Each event sweeps the slot memory one slot per cycle through a single read port
// with registered read data, then passes a drain state and a finish state in which it
// commits and loads the output register; the next event is accepted only once the
// controller is back in idle, so a new event never starts before the last one commits.
// A new event is accepted only while the controller is idle; it may be accepted
// while the previous result still waits in the output register.
// If rsp_tready stays low, the finished event waits before commit until the output
// register frees, and no further event is accepted meanwhile.
// Reset (synchronous, active high) empties the queue at once through the valid bits
// and clears the arrival counter; slot memory contents need no clearing.
// Boost saturates at the signed 32-bit limits; a full queue drops an arrival and
// flags it on rsp_tuser.
module stable_priority_queue_with_boost import spq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [15:0] item_id, [23:16] letter, [55:24] priority_req, [87:56] increment
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] kind
   input  logic [KIND_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] served_id
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] served_valid, [1] dropped
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   cmd_type          cmd;
   status_type       status;
   logic [IDX_W-1:0] rd_idx;

   spq_ctrl #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .rd_idx     (rd_idx)
   );

   spq_dp #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .rd_idx     (rd_idx),
      .status     (status),
      .req_kind   (req_tuser),
      .req_data   (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // busy after an accepted transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !req_tready)
      else $error("input accepted again right after a transaction");

   // commit never overwrites a result the receiver has not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten");

   // commit always presents a result next cycle
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("commit without result");

   // a served entry always reports no drop
   a_serve_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("served and dropped flags both set");

endmodule

>>> bench/stable_priority_queue_with_boost_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the stable priority queue: directed rows, then shaped random traffic.
module stable_priority_queue_with_boost_test;
   import spq_pkg::*;

   localparam int DEPTH = CAPACITY_DEF;
   // The limit covers a full event sweep many times over, plus stalls.
   localparam int STALL_LIMIT = 40 * (DEPTH + 3);
   localparam int ITEMS_PER_PHASE = 530;

   localparam logic [KIND_W-1:0]   KIND_UNUSED = 2'd3;
   localparam logic [LETTER_W-1:0] TAG_C = "C";
   localparam logic [LETTER_W-1:0] TAG_S = "S";
   localparam logic [LETTER_W-1:0] TAG_A = "A";
   localparam logic [LETTER_W-1:0] TAG_X = "X";
   localparam logic signed [PRIO_W-1:0] LEVEL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [PRIO_W-1:0] LEVEL_MIN = 32'sh8000_0000;

   typedef struct {
      logic [KIND_W-1:0]        kind;
      logic [ID_W-1:0]          item_id;
      logic [LETTER_W-1:0]      letter;
      logic signed [PRIO_W-1:0] prio;
      logic signed [PRIO_W-1:0] increment;
   } queue_event_type;

   typedef struct packed {
      logic            served_valid;
      logic [ID_W-1:0] served_id;
      logic            dropped;
   } serve_result_type;

   typedef struct {
      queue_event_type ev;
      bit              typed;  // typed rows all expect an empty result
   } directed_row_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // [15:0] item_id, [23:16] letter,
                                           // [55:24] priority_req, [87:56] increment
   logic [KIND_W-1:0]     req_tuser = '0;  // [1:0] kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // [15:0] served_id
   logic [RSP_USER_W-1:0] rsp_tuser;       // [0] served_valid, [1] dropped

   // shadow copy of the queue
   logic                     shadow_live  [DEPTH];
   logic [ID_W-1:0]          shadow_id    [DEPTH];
   logic [LETTER_W-1:0]      shadow_tag   [DEPTH];
   logic signed [PRIO_W-1:0] shadow_level [DEPTH];
   logic [STAMP_W-1:0]       shadow_stamp [DEPTH];
   logic [STAMP_W-1:0]       shadow_next_stamp;
   int                       shadow_count;

   serve_result_type owed[$];
   directed_row_type directed_rows[$];
   int               failures = 0;
   int               stall_cycles = 0;
   int unsigned      sender_idle_pct = 0;
   int unsigned      receiver_idle_pct = 0;

   stable_priority_queue_with_boost #(
      .CAPACITY(DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one event to the shadow queue and returns the result it owes.
   function automatic serve_result_type shadow_event(input queue_event_type ev);
      serve_result_type r;
      int               slot;
      longint           sum;
      r = '0;
      slot = -1;
      case (ev.kind)
         KIND_ARRIVE: begin
            for (int i = 0; i < DEPTH && slot < 0; i++)
               if (!shadow_live[i]) slot = i;
            if (slot < 0) begin
               r.dropped = 1'b1;
            end else begin
               shadow_live[slot]  = 1'b1;
               shadow_id[slot]    = ev.item_id;
               shadow_tag[slot]   = ev.letter;
               shadow_level[slot] = ev.prio;
               shadow_stamp[slot] = shadow_next_stamp;
               shadow_next_stamp  = shadow_next_stamp + 1;
               shadow_count++;
            end
         end
         KIND_BOOST: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (shadow_live[i] && shadow_tag[i] == ev.letter) begin
                  sum = longint'(shadow_level[i]) + longint'(ev.increment);
                  if (sum > longint'(LEVEL_MAX))      shadow_level[i] = LEVEL_MAX;
                  else if (sum < longint'(LEVEL_MIN)) shadow_level[i] = LEVEL_MIN;
                  else                                shadow_level[i] = PRIO_W'(sum);
               end
            end
         end
         KIND_SERVE: begin
            // higher level wins; on a tie the older stamp (unsigned) wins
            for (int i = 0; i < DEPTH; i++) begin
               if (shadow_live[i] && (slot < 0 || shadow_level[i] > shadow_level[slot] ||
                   (shadow_level[i] == shadow_level[slot] &&
                    shadow_stamp[i] < shadow_stamp[slot])))
                  slot = i;
            end
            if (slot >= 0) begin
               shadow_live[slot] = 1'b0;
               r.served_valid = 1'b1;
               r.served_id = shadow_id[slot];
               shadow_count--;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Small levels in nearly half the picks so ties are common, some extremes for saturation.
   function automatic logic signed [PRIO_W-1:0] pick_level();
      int unsigned roll;
      int          near;
      roll = $urandom_range(99);
      near = int'($urandom_range(6)) - 3;
      if (roll < 45) return near;
      if (roll < 65) begin
         case ($urandom_range(3))
            0:       return LEVEL_MAX;
            1:       return LEVEL_MIN;
            2:       return LEVEL_MAX - 1;
            default: return LEVEL_MIN + 1;
         endcase
      end
      return $urandom();
   endfunction

   function automatic queue_event_type random_event(input int unsigned arrive_pct,
                                                    input int unsigned serve_pct);
      queue_event_type ev;
      int unsigned     roll;
      roll = $urandom_range(99);
      if (roll < arrive_pct)                  ev.kind = KIND_ARRIVE;
      else if (roll < arrive_pct + serve_pct) ev.kind = KIND_SERVE;
      else if (roll < 96)                     ev.kind = KIND_BOOST;
      else                                    ev.kind = KIND_UNUSED;
      ev.item_id = ID_W'($urandom());
      if ($urandom_range(99) < 70) begin
         case ($urandom_range(2))
            0:       ev.letter = TAG_C;
            1:       ev.letter = TAG_S;
            default: ev.letter = TAG_A;
         endcase
      end else begin
         ev.letter = LETTER_W'($urandom());
      end
      ev.prio = pick_level();
      ev.increment = pick_level();
      return ev;
   endfunction

   task automatic send_event(input queue_event_type ev, input bit typed);
      serve_result_type outcome;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= ev.kind;
      req_tdata  <= {ev.increment, ev.prio, ev.letter, ev.item_id};
      do @(posedge clock); while (!req_tready);
      outcome = shadow_event(ev);
      owed.insert(owed.size(), typed ? serve_result_type'('0) : outcome);
   endtask

   task automatic add_row(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                          input logic [LETTER_W-1:0] tag,
                          input logic signed [PRIO_W-1:0] level,
                          input logic signed [PRIO_W-1:0] inc, input bit typed);
      directed_row_type row;
      row.ev.kind      = kind;
      row.ev.item_id   = id;
      row.ev.letter    = tag;
      row.ev.prio      = level;
      row.ev.increment = inc;
      row.typed        = typed;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // Fill runs push the queue to full and past it, drain runs serve it empty and past it.
   task automatic run_random(input int unsigned quota);
      int unsigned     sent;
      int unsigned     mode;
      int unsigned     run_len;
      queue_event_type ev;
      sent = 0;
      mode = 0;
      while (sent < quota) begin
         run_len = (mode == 1) ? $urandom_range(20, 80) : $urandom_range(90, 140);
         for (int n = 0; n < run_len && sent < quota; n++) begin
            case (mode)
               0:       ev = random_event(75, 10);
               1:       ev = random_event(40, 35);
               default: ev = random_event(10, 75);
            endcase
            send_event(ev, 1'b0);
            if (ev.kind != KIND_UNUSED) sent++;
         end
         mode = (mode + 1) % 3;
      end
   endtask

   task automatic check_outcome();
      serve_result_type want;
      if (owed.size() == 0) begin
         $error("result transaction with nothing outstanding: tdata %h tuser %b",
                rsp_tdata, rsp_tuser);
         failures++;
      end else begin
         want = owed.pop_front();
         if (rsp_tuser[0] !== want.served_valid) begin
            $error("served_valid: expected %0b, got %0b", want.served_valid, rsp_tuser[0]);
            failures++;
         end
         if (rsp_tdata !== want.served_id) begin
            $error("served_id: expected %h, got %h", want.served_id, rsp_tdata);
            failures++;
         end
         if (rsp_tuser[1] !== want.dropped) begin
            $error("dropped: expected %0b, got %0b", want.dropped, rsp_tuser[1]);
            failures++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_outcome();
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("** stable_priority_queue_with_boost: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < DEPTH; i++) shadow_live[i] = 1'b0;
      shadow_next_stamp = '0;
      shadow_count = 0;

      add_row(KIND_SERVE,  16'h0000, TAG_C,  32'sd0,   32'sd0,  1'b1);  // empty queue
      add_row(KIND_UNUSED, 16'hFFFF, 8'hFF,  -32'sd1,  -32'sd1, 1'b1);
      add_row(KIND_ARRIVE, 16'hFFFF, TAG_C,  LEVEL_MAX, 32'sd0, 1'b1);
      add_row(KIND_ARRIVE, 16'h0000, TAG_S,  LEVEL_MIN, 32'sd0, 1'b1);
      add_row(KIND_ARRIVE, 16'h1234, TAG_A,  32'sd5,   32'sd0,  1'b1);
      add_row(KIND_ARRIVE, 16'h1235, TAG_A,  32'sd5,   32'sd0,  1'b1);
      add_row(KIND_ARRIVE, 16'h00FF, 8'hFF,  -32'sd1,  32'sd0,  1'b1);
      add_row(KIND_ARRIVE, 16'h8000, 8'h00,  32'sd5,   32'sd0,  1'b1);
      add_row(KIND_BOOST,  16'h0000, TAG_C,  32'sd0,   LEVEL_MAX, 1'b1);  // clamps high
      add_row(KIND_BOOST,  16'h0000, TAG_S,  32'sd0,   LEVEL_MIN, 1'b1);  // clamps low
      add_row(KIND_BOOST,  16'h0000, TAG_A,  32'sd0,   -32'sd5, 1'b1);
      add_row(KIND_BOOST,  16'h0000, TAG_X,  32'sd0,   LEVEL_MAX, 1'b1);  // no match
      add_row(KIND_BOOST,  16'h0000, 8'hFF,  32'sd0,   LEVEL_MIN, 1'b1);
      add_row(KIND_SERVE,  16'h0000, TAG_C,  32'sd0,   32'sd0,  1'b0);
      add_row(KIND_SERVE,  16'h0000, TAG_C,  32'sd0,   32'sd0,  1'b0);
      add_row(KIND_SERVE,  16'h0000, TAG_C,  32'sd0,   32'sd0,  1'b0);  // tie, older first
      add_row(KIND_SERVE,  16'h0000, TAG_C,  32'sd0,   32'sd0,  1'b0);
      add_row(KIND_SERVE,  16'h0000, TAG_C,  32'sd0,   32'sd0,  1'b0);  // tie at the floor
      add_row(KIND_SERVE,  16'h0000, TAG_C,  32'sd0,   32'sd0,  1'b0);
      add_row(KIND_SERVE,  16'hFFFF, 8'hFF,  -32'sd1,  -32'sd1, 1'b1);  // empty again

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               sender_idle_pct = 30;
               receiver_idle_pct = 66;
            end
            1: begin
               sender_idle_pct = 66;
               receiver_idle_pct = 30;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
         endcase
         if (p == 0) begin
            foreach (directed_rows[r]) send_event(directed_rows[r].ev, directed_rows[r].typed);
         end else begin
            // hold off until the block has returned everything
            req_tvalid <= 1'b0;
            do @(posedge clock); while (owed.size() != 0);
         end
         run_random(ITEMS_PER_PHASE);
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (owed.size() != 0);
      repeat (DEPTH + 8) @(posedge clock);
      if (failures == 0) begin
         $display("** stable_priority_queue_with_boost: PASSED **");
      end else begin
         $display("** stable_priority_queue_with_boost: FAILED **");
      end
      $finish;
   end

endmodule
